// ===== rtl/tvbt_pkg.sv =====
// ----------------------------------------------------------------------------
// tvbt_pkg
// Operation and status codes, word geometry and controller states shared by
// the triangular visibility bit table.
// ----------------------------------------------------------------------------
package tvbt_pkg;

  // Operation codes carried on the request channel
  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_RECORD = 3'd2;
  localparam logic [2:0] OP_QUERY  = 3'd3;
  localparam logic [2:0] OP_LOOKUP = 3'd4;

  // Status codes carried on the response channel
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NO_PAIR = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  // Relation words are 32 bits wide; a column selects word and bit
  localparam int WORD_BITS  = 32;
  localparam int WORD_SHIFT = 5;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_MODIFY,
    S_ZERO,
    S_FIN
  } state_e;

endpackage

// ===== rtl/tvbt_req_if.sv =====
// ----------------------------------------------------------------------------
// tvbt_req_if
// Request channel: one operation with its bit value and lookup cells.
// ----------------------------------------------------------------------------
interface tvbt_req_if;

  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic       visible;
  logic [7:0] cell_a;
  logic [7:0] cell_b;

  modport source (
    output valid, operation, visible, cell_a, cell_b,
    input  ready
  );

  modport sink (
    input  valid, operation, visible, cell_a, cell_b,
    output ready
  );

endinterface

// ===== rtl/tvbt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tvbt_rsp_if
// Response channel: status, pending pair, looked-up bit and cell count.
// ----------------------------------------------------------------------------
interface tvbt_rsp_if;

  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       pair_pending;
  logic [7:0] pending_row;
  logic [7:0] pending_col;
  logic       bit_out;
  logic [8:0] cell_count;

  modport source (
    output valid, status, pair_pending, pending_row, pending_col, bit_out,
           cell_count,
    input  ready
  );

  modport sink (
    input  valid, status, pair_pending, pending_row, pending_col, bit_out,
           cell_count,
    output ready
  );

endinterface

// ===== rtl/tvbt_ram.sv =====
// ----------------------------------------------------------------------------
// tvbt_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module tvbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write on enable with write; otherwise read and hold the word
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/triangular_visibility_bit_table.sv =====
// ----------------------------------------------------------------------------
// triangular_visibility_bit_table
// Symmetric pairwise bit relation kept as a lower-triangular bit matrix in a
// single-port word RAM, with a cell count and a row/column fill cursor.
//
//   channel  dir  payload                                        transfer
//   req_i    in   operation, visible, cell_a, cell_b             valid & ready
//   rsp_o    out  status, pair_pending, pending_row/col,         valid & ready
//                 bit_out, cell_count
//
// One request at a time. Clear, lookup, failed operations and a query off
// the diagonal go from idle straight to finish; record and a query on the
// diagonal pass through modify (one read-modify-write of the RAM port). Add
// cell zeroes new row n, one row word per cycle through the RAM port. Reset
// clears only the state, count, cursor and response valid; RAM words are
// zeroed by add cell. A new request is taken while a response waits; the next
// response holds until the response register is free.
// ----------------------------------------------------------------------------
module triangular_visibility_bit_table
  import tvbt_pkg::*;
#(
  parameter int MAX_CELL_COUNT = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tvbt_req_if.sink      req_i,
  tvbt_rsp_if.source    rsp_o
);

  localparam int ROW_WORDS = (MAX_CELL_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int DEPTH     = MAX_CELL_COUNT * ROW_WORDS;
  localparam int AW        = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(MAX_CELL_COUNT + 1);
  localparam int COL_W     = $clog2(MAX_CELL_COUNT);
  localparam int WSEL_W    = (COL_W > WORD_SHIFT) ? COL_W - WORD_SHIFT : 1;
  localparam int CMP_W     = (CNT_W > 9) ? CNT_W : 9;

  state_e state_q, state_d;

  logic [CNT_W-1:0]      cells_q, cells_d;
  logic [CNT_W-1:0]      crow_q, crow_d;
  logic [COL_W-1:0]      ccol_q, ccol_d;
  logic [WSEL_W-1:0]     zw_q, zw_d;
  logic [2:0]            op_q, op_d;
  logic                  vis_q, vis_d;
  logic                  err_q, err_d;
  logic [WORD_SHIFT-1:0] lsel_q, lsel_d;

  logic       out_valid_q, out_valid_d;
  logic [1:0] out_status_q, out_status_d;
  logic       out_pend_q, out_pend_d;
  logic [7:0] out_prow_q, out_prow_d;
  logic [7:0] out_pcol_q, out_pcol_d;
  logic       out_bit_q, out_bit_d;
  logic [8:0] out_count_q, out_count_d;

  logic accept, out_free;
  logic full, cur_ok, diag, lk_bad, zero_last;
  logic [7:0]  lk_row, lk_col;
  logic [COL_W-1:0]  addr_row;
  logic [WSEL_W-1:0] addr_wsel;

  logic                 ram_en, ram_we;
  logic [AW-1:0]        ram_addr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  // Handshake
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || rsp_o.ready;

  // Conditions on the table state
  assign full      = (cells_q >= CNT_W'(MAX_CELL_COUNT));
  assign cur_ok    = (crow_q < cells_q);
  assign diag      = (CNT_W'(ccol_q) == crow_q) && cur_ok;
  assign zero_last = (zw_q == WSEL_W'(cells_q >> WORD_SHIFT));

  // Order lookup cells so the larger one is the row
  assign lk_row = (req_i.cell_a < req_i.cell_b) ? req_i.cell_b : req_i.cell_a;
  assign lk_col = (req_i.cell_a < req_i.cell_b) ? req_i.cell_a : req_i.cell_b;
  assign lk_bad = (CMP_W'(lk_row) >= CMP_W'(cells_q));

  // Select the row and word, then form the RAM address
  always_comb begin
    addr_row  = COL_W'(crow_q);
    addr_wsel = WSEL_W'(ccol_q >> WORD_SHIFT);
    if (state_q == S_ZERO) begin
      addr_row  = COL_W'(cells_q);
      addr_wsel = zw_q;
    end else if (state_q == S_IDLE && req_i.operation == OP_LOOKUP) begin
      addr_row  = COL_W'(lk_row);
      addr_wsel = WSEL_W'(COL_W'(lk_col) >> WORD_SHIFT);
    end
  end

  assign ram_addr = AW'(addr_row) * AW'(ROW_WORDS) + AW'(addr_wsel);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          unique case (req_i.operation)
            OP_ADD:    state_d = full ? S_FIN : S_ZERO;
            OP_RECORD: state_d = cur_ok ? S_MODIFY : S_FIN;
            OP_QUERY:  state_d = diag ? S_MODIFY : S_FIN;
            default:   state_d = S_FIN;
          endcase
        end
      end
      S_MODIFY: state_d = S_FIN;
      S_ZERO:   state_d = zero_last ? S_FIN : S_ZERO;
      S_FIN:    state_d = out_free ? S_IDLE : S_FIN;
      default:  state_d = S_IDLE;
    endcase
  end

  // RAM control
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          unique case (req_i.operation)
            OP_RECORD: ram_en = cur_ok;
            OP_QUERY:  ram_en = diag;
            OP_LOOKUP: ram_en = !lk_bad;
            default:   ram_en = 1'b0;
          endcase
        end
      end
      S_MODIFY: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        ram_wdata[ccol_q[WORD_SHIFT-1:0]] = (op_q == OP_QUERY) ? 1'b1 : vis_q;
      end
      S_ZERO: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  // Table state, captured request fields and response register
  always_comb begin
    cells_d      = cells_q;
    crow_d       = crow_q;
    ccol_d       = ccol_q;
    zw_d         = zw_q;
    op_d         = op_q;
    vis_d        = vis_q;
    err_d        = err_q;
    lsel_d       = lsel_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_pend_d   = out_pend_q;
    out_prow_d   = out_prow_q;
    out_pcol_d   = out_pcol_q;
    out_bit_d    = out_bit_q;
    out_count_d  = out_count_q;

    if (accept) begin
      op_d   = req_i.operation;
      vis_d  = req_i.visible;
      lsel_d = lk_col[WORD_SHIFT-1:0];
      zw_d   = '0;
      unique case (req_i.operation)
        OP_ADD:    err_d = full;
        OP_RECORD: err_d = !cur_ok;
        OP_LOOKUP: err_d = lk_bad;
        default:   err_d = 1'b0;
      endcase
      if (req_i.operation == OP_CLEAR) begin
        cells_d = '0;
        crow_d  = '0;
        ccol_d  = '0;
      end
    end

    // Advance the cursor after the bit is written
    if (state_q == S_MODIFY) begin
      if (CNT_W'(ccol_q) == crow_q) begin
        crow_d = crow_q + 1'b1;
        ccol_d = '0;
      end else begin
        ccol_d = ccol_q + 1'b1;
      end
    end

    // Step through the new row; count the cell after the last word
    if (state_q == S_ZERO) begin
      zw_d = zw_q + 1'b1;
      if (zero_last) begin
        cells_d = cells_q + 1'b1;
      end
    end

    // Load the response
    if (state_q == S_FIN && out_free) begin
      out_valid_d  = 1'b1;
      out_status_d = ST_OK;
      out_pend_d   = 1'b0;
      out_prow_d   = '0;
      out_pcol_d   = '0;
      out_bit_d    = 1'b0;
      out_count_d  = 9'(cells_q);
      unique case (op_q)
        OP_ADD:    out_status_d = err_q ? ST_FULL : ST_OK;
        OP_RECORD: out_status_d = err_q ? ST_NO_PAIR : ST_OK;
        OP_QUERY: begin
          if (cur_ok) begin
            out_pend_d = 1'b1;
            out_prow_d = 8'(crow_q);
            out_pcol_d = 8'(ccol_q);
          end else begin
            out_status_d = ST_NO_PAIR;
          end
        end
        OP_LOOKUP: begin
          out_status_d = err_q ? ST_RANGE : ST_OK;
          out_bit_d    = !err_q && ram_rdata[lsel_q];
        end
        default: out_status_d = ST_OK;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cells_q     <= '0;
      crow_q      <= '0;
      ccol_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cells_q     <= cells_d;
      crow_q      <= crow_d;
      ccol_q      <= ccol_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    zw_q         <= zw_d;
    op_q         <= op_d;
    vis_q        <= vis_d;
    err_q        <= err_d;
    lsel_q       <= lsel_d;
    out_status_q <= out_status_d;
    out_pend_q   <= out_pend_d;
    out_prow_q   <= out_prow_d;
    out_pcol_q   <= out_pcol_d;
    out_bit_q    <= out_bit_d;
    out_count_q  <= out_count_d;
  end

  // Relation word store
  tvbt_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Drive the response channel
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.pair_pending = out_pend_q;
  assign rsp_o.pending_row  = out_prow_q;
  assign rsp_o.pending_col  = out_pcol_q;
  assign rsp_o.bit_out      = out_bit_q;
  assign rsp_o.cell_count   = out_count_q;

endmodule
